// ----- rtl/curvature_drive_mixer_assert.svh -----
// Assertion macros shared by the curvature drive mixer checkers.
`ifndef CURVATURE_DRIVE_MIXER_ASSERT_SVH
`define CURVATURE_DRIVE_MIXER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cdm_pkg.sv -----
// Shared types and constants of the curvature drive mixer.
`timescale 1ns / 1ps

package cdm_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

  // Register reset values and clamps.
  localparam logic [14:0] ALPHA_RST = 15'd1638;
  localparam logic [14:0] ALPHA_MAX = 15'd16384;
  localparam logic [15:0] GAIN_RST  = 16'd16384;
  localparam logic [15:0] GAIN_MAX  = 16'd32768;

  // Divider: one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = 15;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SQS,
    OP_SQR,
    OP_RSQ,
    OP_GAIN,
    OP_ROT,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_MIX,
    OP_CLIP,
    OP_BIG,
    OP_DSET,
    OP_DIV,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic quick;
    logic over;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/curvature_drive_mixer.sv -----
// Each accepted beat walks the sequencer states in order; quick-turn mode adds M3 and CLIP,
// and the 15-step two-lane restoring divider runs only when an output must be normalized.
// One item is in work at a time, through the shared 18x18 multiplier sequence and the divider;
// a stalled result holds the following item in its last step.
// Reset: asynchronous active low; restores register defaults and clears the
// quick-stop accumulator; no result is pending after reset.
`timescale 1ns / 1ps

module curvature_drive_mixer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            speed_cmd_i,
  input  logic signed [15:0]            rotation_cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            left_drive_o,
  output logic signed [15:0]            right_drive_o,
  output logic                          quick_turn_o
);

  cdm_pkg::cmd_t cmd;
  cdm_pkg::sts_t sts;

  // Sequencer.
  cdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and result register.
  cdm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .speed_cmd_i    (speed_cmd_i),
    .rotation_cmd_i (rotation_cmd_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .left_drive_o   (left_drive_o),
    .right_drive_o  (right_drive_o),
    .quick_turn_o   (quick_turn_o)
  );

endmodule

// ----- rtl/cdm_ctrl.sv -----
// Sequencing state machine of the curvature drive mixer.
`timescale 1ns / 1ps

module cdm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cdm_pkg::sts_t sts_i,
  output cdm_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQS  = 4'd1;
  localparam logic [3:0] S_SQR  = 4'd2;
  localparam logic [3:0] S_RSQ  = 4'd3;
  localparam logic [3:0] S_GAIN = 4'd4;
  localparam logic [3:0] S_ROT  = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_M3   = 4'd8;
  localparam logic [3:0] S_MIX  = 4'd9;
  localparam logic [3:0] S_CLIP = 4'd10;
  localparam logic [3:0] S_BIG  = 4'd11;
  localparam logic [3:0] S_DSET = 4'd12;
  localparam logic [3:0] S_DIV  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  localparam logic [cdm_pkg::CNT_W-1:0] CNT_LAST = cdm_pkg::CNT_W'(cdm_pkg::DIV_STEPS - 1);

  logic [3:0]                state_q, state_d;
  logic [cdm_pkg::CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and divider step count.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_SQS;
      S_SQS:  state_d = S_SQR;
      S_SQR:  state_d = S_RSQ;
      S_RSQ:  state_d = S_GAIN;
      S_GAIN: state_d = S_ROT;
      S_ROT:  state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = sts_i.quick ? S_M3 : S_MIX;
      S_M3:   state_d = S_MIX;
      S_MIX:  state_d = sts_i.quick ? S_CLIP : S_BIG;
      S_CLIP: state_d = S_BIG;
      S_BIG:  state_d = S_DSET;
      S_DSET: begin
        cnt_d   = '0;
        state_d = sts_i.over ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN:  if (!sts_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Operation issued to the datapath in each state.
  always_comb begin
    case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? cdm_pkg::OP_LOAD : cdm_pkg::OP_IDLE;
      S_SQS:   cmd_o.op = cdm_pkg::OP_SQS;
      S_SQR:   cmd_o.op = cdm_pkg::OP_SQR;
      S_RSQ:   cmd_o.op = cdm_pkg::OP_RSQ;
      S_GAIN:  cmd_o.op = cdm_pkg::OP_GAIN;
      S_ROT:   cmd_o.op = cdm_pkg::OP_ROT;
      S_M1:    cmd_o.op = cdm_pkg::OP_M1;
      S_M2:    cmd_o.op = cdm_pkg::OP_M2;
      S_M3:    cmd_o.op = cdm_pkg::OP_M3;
      S_MIX:   cmd_o.op = cdm_pkg::OP_MIX;
      S_CLIP:  cmd_o.op = cdm_pkg::OP_CLIP;
      S_BIG:   cmd_o.op = cdm_pkg::OP_BIG;
      S_DSET:  cmd_o.op = cdm_pkg::OP_DSET;
      S_DIV:   cmd_o.op = cdm_pkg::OP_DIV;
      S_FIN:   cmd_o.op = cdm_pkg::OP_FIN;
      default: cmd_o.op = cdm_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/cdm_datapath.sv -----
// Arithmetic datapath of the curvature drive mixer: multiplier, mixing and divider.
`timescale 1ns / 1ps

module cdm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cdm_pkg::cmd_t                       cmd_i,
  output cdm_pkg::sts_t                       sts_o,
  input  logic                                cfg_we_i,
  input  logic [cdm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [15:0]                         cfg_wdata_i,
  input  logic signed [15:0]                  speed_cmd_i,
  input  logic signed [15:0]                  rotation_cmd_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [15:0]                  left_drive_o,
  output logic signed [15:0]                  right_drive_o,
  output logic                                quick_turn_o
);

  localparam logic signed [18:0] ONE_W     = 19'sd16384;
  localparam logic signed [18:0] NEG_ONE_W = -19'sd16384;
  localparam logic [16:0]        TENTH     = 17'd1638;
  localparam logic [17:0]        ONE_MAG   = 18'd16384;

  // Divide by 16384, rounding to nearest with ties away from zero.
  function automatic logic signed [21:0] rnd_q14(input logic signed [35:0] v);
    logic [35:0] mag;
    logic [21:0] m;
    mag = v[35] ? 36'(-v) : 36'(v);
    m   = 22'((mag + 36'd8192) >> 14);
    return v[35] ? -$signed(m) : $signed(m);
  endfunction

  // Saturate a command to +-1.0.
  function automatic logic signed [16:0] sat_cmd(input logic signed [15:0] v);
    logic signed [16:0] r;
    if (v > 16'sd16384) begin
      r = 17'sd16384;
    end else if (v < -16'sd16384) begin
      r = -17'sd16384;
    end else begin
      r = {v[15], v};
    end
    return r;
  endfunction

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic [17:0] abs19(input logic signed [18:0] v);
    return v[18] ? 18'(-v) : 18'(v);
  endfunction

  // One restoring division step: returns the quotient bit over the new remainder.
  function automatic logic [18:0] div_step(input logic [17:0] rem, input logic nb,
                                           input logic [17:0] den);
    logic [18:0] t;
    logic [18:0] r;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      r = {1'b1, 18'(t - {1'b0, den})};
    end else begin
      r = {1'b0, t[17:0]};
    end
    return r;
  endfunction

  // Configuration and persistent state.
  logic [14:0]        alpha_q;
  logic [15:0]        gain_q;
  logic signed [17:0] acc_q;

  // Per-item working registers.
  logic signed [16:0] spd_q, rot_q;
  logic signed [35:0] prod_q, p1_q;
  logic signed [18:0] ang_q, left_q, right_q;
  logic               quick_q;
  logic [17:0]        mag_l_q, mag_r_q, big_q;
  logic [17:0]        rem_l_q, rem_r_q;
  logic [14:0]        lo_l_q, lo_r_q, quo_l_q, quo_r_q;

  // Result beat register.
  logic               out_valid_q;
  logic signed [15:0] out_left_q, out_right_q;
  logic               out_quick_q;

  logic [14:0]        alpha_c;
  logic [15:0]        gain_c;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod_d;
  logic signed [21:0] rnd_prod, rnd_sum;
  logic signed [18:0] clip_l, clip_r;
  logic [31:0]        num_l, num_r;
  logic [18:0]        step_l, step_r;
  logic signed [15:0] fin_l, fin_r;
  logic               load_out;

  assign alpha_c = (alpha_q > cdm_pkg::ALPHA_MAX) ? cdm_pkg::ALPHA_MAX : alpha_q;
  assign gain_c  = (gain_q > cdm_pkg::GAIN_MAX) ? cdm_pkg::GAIN_MAX : gain_q;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      cdm_pkg::OP_SQS: begin
        mul_a = {spd_q[16], spd_q};
        mul_b = $signed({1'b0, abs17(spd_q)});
      end
      cdm_pkg::OP_SQR: begin
        mul_a = {rot_q[16], rot_q};
        mul_b = $signed({1'b0, abs17(rot_q)});
      end
      cdm_pkg::OP_GAIN: begin
        mul_a = {rot_q[16], rot_q};
        mul_b = $signed({2'b00, gain_c});
      end
      cdm_pkg::OP_M1: begin
        if (quick_q) begin
          mul_a = $signed({3'b000, 15'(cdm_pkg::ALPHA_MAX - alpha_c)});
          mul_b = acc_q;
        end else begin
          mul_a = $signed({1'b0, abs17(spd_q)});
          mul_b = {rot_q[16], rot_q};
        end
      end
      cdm_pkg::OP_M2: begin
        mul_a = $signed({3'b000, alpha_c});
        mul_b = {rot_q, 1'b0};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign rnd_prod = rnd_q14(prod_q);
  assign rnd_sum  = rnd_q14(p1_q + prod_q);

  // Quick-turn clipping moves the excess of one side to the other.
  always_comb begin
    clip_l = left_q;
    clip_r = right_q;
    if (left_q > ONE_W) begin
      clip_r = right_q - (left_q - ONE_W);
      clip_l = ONE_W;
    end else if (right_q > ONE_W) begin
      clip_l = left_q - (right_q - ONE_W);
      clip_r = ONE_W;
    end else if (left_q < NEG_ONE_W) begin
      clip_r = right_q - (left_q + ONE_W);
      clip_l = NEG_ONE_W;
    end else if (right_q < NEG_ONE_W) begin
      clip_l = left_q - (right_q + ONE_W);
      clip_r = NEG_ONE_W;
    end
  end

  // Dividend |v| * 16384 + big / 2 for the normalizing division.
  assign num_l = {mag_l_q, 14'b0} + {15'b0, big_q[17:1]};
  assign num_r = {mag_r_q, 14'b0} + {15'b0, big_q[17:1]};

  assign step_l = div_step(rem_l_q, lo_l_q[14], big_q);
  assign step_r = div_step(rem_r_q, lo_r_q[14], big_q);

  // Final values: quotient with the sign restored, or the mix when no scaling applies.
  always_comb begin
    if (big_q > ONE_MAG) begin
      fin_l = left_q[18] ? 16'(-$signed({1'b0, quo_l_q})) : $signed({1'b0, quo_l_q});
      fin_r = right_q[18] ? 16'(-$signed({1'b0, quo_r_q})) : $signed({1'b0, quo_r_q});
    end else begin
      fin_l = left_q[15:0];
      fin_r = right_q[15:0];
    end
  end

  assign sts_o.quick    = quick_q;
  assign sts_o.over     = (big_q > ONE_MAG);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign load_out       = (cmd_i.op == cdm_pkg::OP_FIN) && !sts_o.out_busy;

  // Configuration registers, accumulator and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= cdm_pkg::ALPHA_RST;
      gain_q      <= cdm_pkg::GAIN_RST;
      acc_q       <= '0;
      quick_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cdm_pkg::REG_ALPHA: alpha_q <= cfg_wdata_i[14:0];
          cdm_pkg::REG_GAIN:  gain_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.op == cdm_pkg::OP_ROT) begin
        quick_q <= (abs17(spd_q) < TENTH) && (abs17(rnd_prod[16:0]) > TENTH);
      end
      if (cmd_i.op == cdm_pkg::OP_M3) begin
        acc_q <= rnd_sum[17:0];
      end else if (cmd_i.op == cdm_pkg::OP_M2 && !quick_q) begin
        if (acc_q > 18'sd16384) begin
          acc_q <= acc_q - 18'sd16384;
        end else if (acc_q < -18'sd16384) begin
          acc_q <= acc_q + 18'sd16384;
        end else begin
          acc_q <= '0;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers, stepped by the controller's operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op inside {cdm_pkg::OP_SQS, cdm_pkg::OP_SQR, cdm_pkg::OP_GAIN,
                         cdm_pkg::OP_M1, cdm_pkg::OP_M2}) begin
      prod_q <= prod_d;
    end
    case (cmd_i.op)
      cdm_pkg::OP_LOAD: begin
        spd_q <= sat_cmd(speed_cmd_i);
        rot_q <= sat_cmd(rotation_cmd_i);
      end
      cdm_pkg::OP_SQR: spd_q <= rnd_prod[16:0];
      cdm_pkg::OP_RSQ: rot_q <= rnd_prod[16:0];
      cdm_pkg::OP_ROT: rot_q <= rnd_prod[16:0];
      cdm_pkg::OP_M2: begin
        if (quick_q) begin
          p1_q  <= prod_q;
          ang_q <= {{2{rot_q[16]}}, rot_q};
        end else begin
          ang_q <= rnd_prod[18:0] - {acc_q[17], acc_q};
        end
      end
      cdm_pkg::OP_MIX: begin
        left_q  <= {{2{spd_q[16]}}, spd_q} + ang_q;
        right_q <= {{2{spd_q[16]}}, spd_q} - ang_q;
      end
      cdm_pkg::OP_CLIP: begin
        left_q  <= clip_l;
        right_q <= clip_r;
      end
      cdm_pkg::OP_BIG: begin
        mag_l_q <= abs19(left_q);
        mag_r_q <= abs19(right_q);
        big_q   <= (abs19(left_q) > abs19(right_q)) ? abs19(left_q) : abs19(right_q);
      end
      cdm_pkg::OP_DSET: begin
        rem_l_q <= {1'b0, num_l[31:15]};
        rem_r_q <= {1'b0, num_r[31:15]};
        lo_l_q  <= num_l[14:0];
        lo_r_q  <= num_r[14:0];
        quo_l_q <= '0;
        quo_r_q <= '0;
      end
      cdm_pkg::OP_DIV: begin
        rem_l_q <= step_l[17:0];
        rem_r_q <= step_r[17:0];
        lo_l_q  <= {lo_l_q[13:0], 1'b0};
        lo_r_q  <= {lo_r_q[13:0], 1'b0};
        quo_l_q <= {quo_l_q[13:0], step_l[18]};
        quo_r_q <= {quo_r_q[13:0], step_r[18]};
      end
      default: ;
    endcase
    if (load_out) begin
      out_left_q  <= fin_l;
      out_right_q <= fin_r;
      out_quick_q <= quick_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = out_left_q;
  assign right_drive_o = out_right_q;
  assign quick_turn_o  = out_quick_q;

endmodule

// ----- rtl/cdm_checker.sv -----
// Port-level assertions for the curvature drive mixer and their binding.
`timescale 1ns / 1ps
`include "curvature_drive_mixer_assert.svh"

module cdm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] left_drive_o,
  input logic signed [15:0] right_drive_o,
  input logic               quick_turn_o
);

  // A stalled result beat holds its payload.
  `CDM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(left_drive_o) && $stable(right_drive_o) && $stable(quick_turn_o), "result beat changed while stalled")

  // Both drive outputs stay within full scale.
  `CDM_ASSERT_SAME(a_out_range, out_valid_o, (left_drive_o <= 16'sd16384) && (left_drive_o >= -16'sd16384) && (right_drive_o <= 16'sd16384) && (right_drive_o >= -16'sd16384), "drive output beyond full scale")

  // The block takes one item at a time.
  `CDM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input accepted while an item is in work")

  // A result never appears in the cycle right after an input beat.
  `CDM_ASSERT_SAME(a_no_early_result, $rose(out_valid_o), !$past(in_valid_i && in_ready_o), "result beat too early")

endmodule

bind curvature_drive_mixer cdm_checker u_cdm_checker (.*);

// ----- tb/drive_mix_checker.sv -----
// Beat checker for the curvature drive mixer: tracks registers, predicts and compares results.
`timescale 1ns / 1ps

module drive_mix_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [15:0]            speed_cmd_i,
  input  logic signed [15:0]            rotation_cmd_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [15:0]            left_drive_i,
  input  logic signed [15:0]            right_drive_i,
  input  logic                          quick_turn_i,
  output int                            mismatches_o,
  output int                            pending_o,
  output int                            beats_o,
  output int                            quick_beats_o
);

  import cdm_pkg::*;

  localparam int ONE_Q14   = 16384;
  localparam int HALF_Q14  = 8192;
  localparam int TENTH_Q14 = 1638;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               quick;
  } drive_beat_t;

  // Mirror of the block's registers and quick-stop accumulator.
  logic [14:0] alpha_q;
  logic [15:0] gain_q;
  int          stop_acc;

  drive_beat_t drives_due[$];
  drive_beat_t want;
  drive_beat_t seen;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_unit(input logic signed [15:0] v);
    if (v > ONE_Q14) return ONE_Q14;
    if (v < -ONE_Q14) return -ONE_Q14;
    return int'(v);
  endfunction

  // Divide by 1.0 in Q1.14, rounding half away from zero.
  function automatic int round_q14(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + HALF_Q14) >>> 14;
    return (v < 0) ? -int'(m) : int'(m);
  endfunction

  function automatic int signed_sq(input int v);
    return round_q14(longint'(v) * mag(v));
  endfunction

  // Rescale v by 1.0 / den with rounding; den is above 1.0.
  function automatic int shrink(input int v, input int den);
    longint m;
    m = longint'(mag(v)) * ONE_Q14;
    m = (m + den / 2) / den;
    return (v < 0) ? -int'(m) : int'(m);
  endfunction

  // Works out the drive beat for one command and advances the accumulator.
  task automatic mix_drive(input logic signed [15:0] spd_raw,
                           input logic signed [15:0] rot_raw,
                           output drive_beat_t beat);
    int   a;
    int   g;
    int   spd;
    int   rot;
    int   ang;
    int   lft;
    int   rgt;
    int   big;
    logic quick;
    a = (alpha_q > ALPHA_MAX) ? int'(ALPHA_MAX) : int'(alpha_q);
    g = (gain_q > GAIN_MAX) ? int'(GAIN_MAX) : int'(gain_q);
    spd = signed_sq(clamp_unit(spd_raw));
    rot = round_q14(longint'(signed_sq(clamp_unit(rot_raw))) * g);
    quick = (mag(spd) < TENTH_Q14) && (mag(rot) > TENTH_Q14);

    if (quick) begin
      stop_acc = round_q14(longint'(ONE_Q14 - a) * stop_acc + longint'(a) * 2 * rot);
      ang = rot;
    end else begin
      ang = round_q14(longint'(mag(spd)) * rot) - stop_acc;
      if (stop_acc > ONE_Q14) stop_acc -= ONE_Q14;
      else if (stop_acc < -ONE_Q14) stop_acc += ONE_Q14;
      else stop_acc = 0;
    end

    lft = spd + ang;
    rgt = spd - ang;

    // In quick-turn mode the overshoot of one side moves to the other.
    if (quick) begin
      if (lft > ONE_Q14) begin
        rgt -= lft - ONE_Q14;
        lft = ONE_Q14;
      end else if (rgt > ONE_Q14) begin
        lft -= rgt - ONE_Q14;
        rgt = ONE_Q14;
      end else if (lft < -ONE_Q14) begin
        rgt -= lft + ONE_Q14;
        lft = -ONE_Q14;
      end else if (rgt < -ONE_Q14) begin
        lft -= rgt + ONE_Q14;
        rgt = -ONE_Q14;
      end
    end

    big = (mag(lft) > mag(rgt)) ? mag(lft) : mag(rgt);
    if (big > ONE_Q14) begin
      lft = shrink(lft, big);
      rgt = shrink(rgt, big);
    end

    beat.left  = lft[15:0];
    beat.right = rgt[15:0];
    beat.quick = quick;
  endtask

  task automatic note_mismatch(input string field, input int exp_val, input int act_val);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("[%0t] beat %0d: %s expected %0d, got %0d",
               $realtime, beats_o, field, exp_val, act_val);
    end
  endtask

  // Result beats are compared before the new command is queued, so a result
  // never gets matched against a command taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q       = ALPHA_RST;
      gain_q        = GAIN_RST;
      stop_acc      = 0;
      drives_due.delete();
      mismatches_o  = 0;
      pending_o     = 0;
      beats_o       = 0;
      quick_beats_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ALPHA) alpha_q = cfg_wdata_i[14:0];
        else if (cfg_idx_i == REG_GAIN) gain_q = cfg_wdata_i;
      end

      if (out_valid_i && out_ready_i) begin
        seen.left  = left_drive_i;
        seen.right = right_drive_i;
        seen.quick = quick_turn_i;
        if (drives_due.size() == 0) begin
          note_mismatch("unexpected result beat, quick_turn", 0, int'(seen.quick));
        end else begin
          want = drives_due.pop_front();
          if (seen.left !== want.left)
            note_mismatch("left_drive", int'(want.left), int'(seen.left));
          if (seen.right !== want.right)
            note_mismatch("right_drive", int'(want.right), int'(seen.right));
          if (seen.quick !== want.quick)
            note_mismatch("quick_turn", int'(want.quick), int'(seen.quick));
          if (want.quick) quick_beats_o++;
        end
        beats_o++;
      end

      if (in_valid_i && in_ready_i) begin
        mix_drive(speed_cmd_i, rotation_cmd_i, want);
        drives_due.push_back(want);
      end

      pending_o = drives_due.size();
    end
  end

endmodule

// ----- tb/tb_curvature_drive_mixer.sv -----
// Testbench top for the curvature drive mixer: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_curvature_drive_mixer;

  import cdm_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int PHASES         = 7;
  localparam int RAND_PER_PHASE = 150;
  localparam int DRAIN_CYCLES   = 40;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int {
    CMD_SLOW,
    CMD_NEAR_TENTH,
    CMD_RANGE,
    CMD_WIDE,
    CMD_EXTREME
  } cmd_style_e;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [15:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [15:0]   speed_cmd;
  logic signed [15:0]   rotation_cmd;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [15:0]   left_drive;
  logic signed [15:0]   right_drive;
  logic                 quick_turn;

  int mismatches;
  int pending;
  int beats;
  int quick_beats;
  int idle_cycles;
  int settings_cnt;
  bit in_calm;
  bit out_calm;

  // Directed commands: extremes, saturation, threshold edges, each clip branch,
  // accumulator build-up in quick turn and its decay afterwards.
  int dir_speed[] = '{0, 16384, -16384, 32767, -32768, 0, 0, 0, 0,
                      5179, 5180, 5179, 5179, -5179, 5179, -5179,
                      0, 0, 0, 0, 16384, 8000, 8000, -16384, 100};
  int dir_rot[]   = '{0, 0, 0, 0, 0, 16384, -16384, 32767, -32768,
                      5182, 5182, 5181, 16384, 16384, -16384, -16384,
                      16384, 16384, 16384, 16384, 16384, 0, 0, -16384, -16384};

  always #6 clk = ~clk;

  curvature_drive_mixer u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .speed_cmd_i    (speed_cmd),
    .rotation_cmd_i (rotation_cmd),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .left_drive_o   (left_drive),
    .right_drive_o  (right_drive),
    .quick_turn_o   (quick_turn)
  );

  drive_mix_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .speed_cmd_i    (speed_cmd),
    .rotation_cmd_i (rotation_cmd),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .left_drive_i   (left_drive),
    .right_drive_i  (right_drive),
    .quick_turn_i   (quick_turn),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .beats_o        (beats),
    .quick_beats_o  (quick_beats)
  );

  // Draws one command of the given style; most styles get a random sign.
  function automatic logic signed [15:0] draw_cmd(input cmd_style_e style);
    int v;
    int extremes[7];
    extremes = '{-32768, -16385, -16384, 0, 16384, 16385, 32767};
    case (style)
      CMD_SLOW:       v = $urandom_range(0, 5179);
      CMD_NEAR_TENTH: v = $urandom_range(5170, 5190);
      CMD_RANGE:      v = $urandom_range(0, 16384);
      CMD_WIDE:       v = int'($urandom_range(0, 65535)) - 32768;
      default:        v = extremes[$urandom_range(0, 6)];
    endcase
    if (style != CMD_WIDE && style != CMD_EXTREME && $urandom_range(0, 1)) v = -v;
    return v[15:0];
  endfunction

  // Offers one command beat after a random gap and returns at the falling
  // edge after it was taken, with valid still high.
  task automatic send_cmd(input logic signed [15:0] spd, input logic signed [15:0] rot);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    speed_cmd    <= spd;
    rotation_cmd <= rot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Lets the block run dry so registers can be written safely.
  task automatic drain_block(input int tail);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // Result side: a random stall before each beat, sometimes none at all.
  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: too long without any beat or register write ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a beat", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Main stimulus.
  initial begin
    int         sent;
    int         run_len;
    cmd_style_e s_style;
    cmd_style_e r_style;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_ALPHA;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    speed_cmd    = '0;
    rotation_cmd = '0;
    out_ready    = 1'b0;
    idle_cycles  = 0;
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    settings_cnt = 1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed commands under reset register values.
    foreach (dir_speed[i]) send_cmd(dir_speed[i][15:0], dir_rot[i][15:0]);
    drain_block(4);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          put_reg(REG_ALPHA, 16'd0);
          put_reg(REG_GAIN, 16'd0);
        end
        1: begin
          put_reg(REG_ALPHA, 16'(ALPHA_MAX));
          put_reg(REG_GAIN, GAIN_MAX);
        end
        2: begin
          put_reg(REG_ALPHA, 16'hFFFF);
          put_reg(REG_GAIN, 16'hFFFF);
        end
        3: begin
          put_reg(REG_ALPHA, 16'($urandom_range(0, 16384)));
          put_reg(REG_GAIN, 16'($urandom_range(0, 32768)));
        end
        4: begin
          put_reg(REG_ALPHA, 16'($urandom_range(0, 65535)));
          put_reg(REG_GAIN, 16'($urandom_range(0, 65535)));
        end
        5: begin
          put_reg(REG_ALPHA, 16'($urandom_range(0, 2000)));
          put_reg(REG_GAIN, 16'($urandom_range(16384, 32768)));
        end
        default: begin
          put_reg(REG_ALPHA, 16'(ALPHA_RST));
          put_reg(REG_GAIN, GAIN_RST);
        end
      endcase
      put_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
              16'($urandom_range(0, 65535)));
      settings_cnt++;

      // Quick-turn runs build up the accumulator; mixed commands drain it.
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        if (sent % 50 == 0) begin
          in_calm  = ($urandom_range(0, 3) == 0);
          out_calm = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 2) == 0) begin
          run_len = $urandom_range(1, 8);
          repeat (run_len) begin
            r_style = cmd_style_e'($urandom_range(int'(CMD_RANGE), int'(CMD_EXTREME)));
            send_cmd(draw_cmd(CMD_SLOW), draw_cmd(r_style));
            sent++;
          end
        end else begin
          s_style = cmd_style_e'($urandom_range(int'(CMD_SLOW), int'(CMD_EXTREME)));
          r_style = cmd_style_e'($urandom_range(int'(CMD_SLOW), int'(CMD_EXTREME)));
          send_cmd(draw_cmd(s_style), draw_cmd(r_style));
          sent++;
        end
      end
      drain_block(4);
    end

    drain_block(DRAIN_CYCLES);

    $display("Checked %0d drive beats, %0d of them in quick-turn mode,", beats, quick_beats);
    $display("across %0d register settings including clamped and ignored writes.",
             settings_cnt);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cdm_pkg.sv
rtl/cdm_ctrl.sv
rtl/cdm_datapath.sv
rtl/curvature_drive_mixer.sv
rtl/cdm_checker.sv
tb/drive_mix_checker.sv
tb/tb_curvature_drive_mixer.sv
